[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ird_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ird_pkg;

  // Configuration register indexes
  localparam logic CFG_HEADER_BOUNDARY = 1'b0;
  localparam logic CFG_BIT_BOUNDARY    = 1'b1;

  localparam logic [15:0] HEADER_BOUNDARY_RST = 16'd12500;
  localparam logic [15:0] BIT_BOUNDARY_RST    = 16'd1680;

  // Width of the stored code word and of one byte of it
  localparam int CODE_WIDTH = 32;
  localparam int BYTE_WIDTH = 8;

  // Frame phases
  localparam logic PHASE_HEADER = 1'b0;
  localparam logic PHASE_DATA   = 1'b1;

  typedef struct packed {
    logic [15:0] interval;
    logic        timeout;
  } in_t;

  typedef struct packed {
    logic [15:0] address;
    logic [15:0] command;
    logic        is_repeat;
  } out_t;

  // Contents of the input stage as seen by the decode stage
  typedef struct packed {
    logic valid;
    in_t  item;
  } stage_t;

  // Split a code word into the address and command halves
  function automatic out_t pack_result(input logic [CODE_WIDTH-1:0] code,
                                       input logic rep);
    out_t r;
    r.address   = {code[BYTE_WIDTH-1:0], code[2*BYTE_WIDTH-1:BYTE_WIDTH]};
    r.command   = {code[3*BYTE_WIDTH-1:2*BYTE_WIDTH],
                   code[4*BYTE_WIDTH-1:3*BYTE_WIDTH]};
    r.is_repeat = rep;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ird_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module ird_in_reg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire ird_pkg::in_t in_data,
  input  wire logic         take,
  output ird_pkg::stage_t   stage
);

  logic         valid;
  logic         valid_next;
  ird_pkg::in_t item;

  // Hold the request until the decode stage takes it
  assign in_stall = valid && !take;

  always_comb begin
    valid_next = valid;
    if (in_valid && !in_stall) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

`default_nettype wire

[rtl/ird_core.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ird_core #(
  parameter int DATA_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ird_pkg::stage_t stage,
  input  wire logic [15:0]     hdr_bound,
  input  wire logic [15:0]     bit_bound,
  output logic                 take,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ird_pkg::out_t        out_data
);

  localparam int CNT_W = $clog2(DATA_BITS);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_BITS - 1);

  logic                              phase;
  logic                              phase_next;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  count_next;
  logic [ird_pkg::CODE_WIDTH-1:0]    code_bits;
  logic [ird_pkg::CODE_WIDTH-1:0]    code_bits_next;
  logic [ird_pkg::CODE_WIDTH-1:0]    frame;
  logic [ird_pkg::CODE_WIDTH-1:0]    frame_next;
  logic [ird_pkg::CODE_WIDTH-1:0]    frame_upd;
  logic [ird_pkg::CODE_WIDTH-1:0]    bit_sel;
  logic [6:0]                        cnt_ext;
  logic                              out_free;
  logic                              emit;
  ird_pkg::out_t                     result;

  // Take the staged request whenever the result register can move
  assign out_free = !out_valid || !out_stall;
  assign take     = stage.valid && out_free;

  // One-hot select of the data bit position; positions past the word select nothing
  assign cnt_ext = 7'(count);
  always_comb begin
    for (int i = 0; i < ird_pkg::CODE_WIDTH; i++) begin
      bit_sel[i] = (cnt_ext == 7'(i));
    end
  end

  assign frame_upd = (stage.item.interval > bit_bound) ? (frame | bit_sel)
                                                       : (frame & ~bit_sel);

  // Advance the frame state by one interval
  always_comb begin
    phase_next     = phase;
    count_next     = count;
    code_bits_next = code_bits;
    frame_next     = frame;
    emit           = 1'b0;
    result         = ird_pkg::pack_result(code_bits, 1'b1);
    if (stage.item.timeout) begin
      phase_next = ird_pkg::PHASE_HEADER;
      count_next = '0;
    end else if (phase == ird_pkg::PHASE_HEADER) begin
      if (count == '0) begin
        count_next = CNT_W'(1);
      end else begin
        count_next = '0;
        if (stage.item.interval < hdr_bound) begin
          emit = 1'b1;
        end else begin
          phase_next = ird_pkg::PHASE_DATA;
          frame_next = code_bits;
        end
      end
    end else begin
      frame_next = frame_upd;
      if (count == LAST_BIT) begin
        code_bits_next = frame_upd;
        phase_next     = ird_pkg::PHASE_HEADER;
        count_next     = '0;
        emit           = 1'b1;
        result         = ird_pkg::pack_result(frame_upd, 1'b0);
      end else begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ird_pkg::PHASE_HEADER;
      count     <= '0;
      code_bits <= '0;
      frame     <= '0;
    end else if (take) begin
      phase     <= phase_next;
      count     <= count_next;
      code_bits <= code_bits_next;
      frame     <= frame_next;
    end
  end

  // Load a result, or drop the one just taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data <= result;
    end
  end

  `ASSERT_CLK(a_hdr_count, clk, rst,
    (phase == ird_pkg::PHASE_HEADER) |-> (count <= CNT_W'(1)),
    "header count out of range")
  `ASSERT_CLK(a_timeout, clk, rst,
    (take && stage.item.timeout) |=> ((phase == ird_pkg::PHASE_HEADER) && (count == '0)),
    "timeout did not abandon frame")
  `ASSERT_CLK(a_frame_done, clk, rst,
    (take && !stage.item.timeout && (phase == ird_pkg::PHASE_DATA) && (count == LAST_BIT))
      |=> (out_valid && !out_data.is_repeat),
    "completed frame not reported")
  `ASSERT_CLK(a_no_overwrite, clk, rst,
    (out_valid && out_stall) |=> ($stable(out_data) && out_valid),
    "stalled result overwritten")

endmodule

`default_nettype wire

[rtl/ir_remote_frame_decoder.sv]
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+----------------------------------
// in      | input     | in_valid / in_stall | in_data: interval, timeout
// out     | output    | out_valid/out_stall | out_data: address, command, is_repeat
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One interval is taken every cycle unless a stalled result holds the decode
// stage; an accepted interval is captured in the input register, then decoded,
// and any result that it completes is loaded into the result register.
// The frame state updates once per interval in the decode stage.
// rst is synchronous and active high; it restores the boundaries to their
// defaults and clears phase, count and the stored code.
// A stalled result holds decode; a held request sees in_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module ir_remote_frame_decoder #(
  parameter int DATA_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ird_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ird_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data
);

  logic [15:0]     hdr_bound;
  logic [15:0]     bit_bound;
  logic            take;
  ird_pkg::stage_t stage;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_bound <= ird_pkg::HEADER_BOUNDARY_RST;
      bit_bound <= ird_pkg::BIT_BOUNDARY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ird_pkg::CFG_HEADER_BOUNDARY: hdr_bound <= cfg_data;
        ird_pkg::CFG_BIT_BOUNDARY:    bit_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  ird_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .stage    (stage)
  );

  ird_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .hdr_bound (hdr_bound),
    .bit_bound (bit_bound),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
